### hw/rtl/serial_command_decoder_assert.svh
// assertion macros shared by the rtl of the serial command decoder
// no dependencies; the clock and reset are passed in by the caller
`ifndef SERIAL_COMMAND_DECODER_ASSERT_SVH
`define SERIAL_COMMAND_DECODER_ASSERT_SVH

// property checked at every rising edge outside reset
`define SCD_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define SCD_NEVER(label, clk, rst_n, cond, msg) \
	`SCD_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

### hw/rtl/scd_pkg.sv
// types and constants of the serial command decoder
// no dependencies; used by the parser and the top level
package scd_pkg;

	localparam int NUM_SETTINGS = 8;
	localparam int SET_IDX_W    = 3;
	localparam int TGT_W        = 4;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_C,
		ST_CC,
		ST_CM,
		ST_CR,
		ST_CT,
		ST_D,
		ST_E,
		ST_EM,
		ST_ER,
		ST_ET,
		ST_I,
		ST_S,
		ST_T,
		ST_X,
		ST_Y,
		ST_NUM
	} st_t;

	typedef enum logic [2:0] {
		KIND_REPLY     = 3'd0,
		KIND_TRANSLATE = 3'd1,
		KIND_ROTATE    = 3'd2,
		KIND_RESET_SP  = 3'd3,
		KIND_SET_WRITE = 3'd4,
		KIND_ENABLE    = 3'd5
	} kind_t;

	// setting indexes
	localparam logic [SET_IDX_W-1:0] SET_PWM_ROT = 3'd0;
	localparam logic [SET_IDX_W-1:0] SET_PWM_TR  = 3'd1;
	localparam logic [SET_IDX_W-1:0] SET_ROT_KP  = 3'd2;
	localparam logic [SET_IDX_W-1:0] SET_ROT_KI  = 3'd3;
	localparam logic [SET_IDX_W-1:0] SET_ROT_KD  = 3'd4;
	localparam logic [SET_IDX_W-1:0] SET_TR_KP   = 3'd5;
	localparam logic [SET_IDX_W-1:0] SET_TR_KI   = 3'd6;
	localparam logic [SET_IDX_W-1:0] SET_TR_KD   = 3'd7;
	localparam logic [SET_IDX_W-1:0] NO_INDEX    = 3'd0;

	// argument targets beyond the eight setting indexes
	localparam logic [TGT_W-1:0] TGT_DISCARD = 4'd8;
	localparam logic [TGT_W-1:0] TGT_TR_POS  = 4'd9;
	localparam logic [TGT_W-1:0] TGT_TR_NEG  = 4'd10;
	localparam logic [TGT_W-1:0] TGT_RO_POS  = 4'd11;
	localparam logic [TGT_W-1:0] TGT_RO_NEG  = 4'd12;

	typedef struct packed {
		logic [7:0]         rx_byte;
		logic signed [31:0] position_x;
		logic signed [31:0] position_y;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         result_kind;
		logic [2:0]         setting_index;
		logic signed [31:0] value;
		logic               loop_enable;
	} out_item_t;

endpackage

### hw/rtl/scd_stream_if.sv
// valid/ready channel carrying one item of a given payload type
// no dependencies; payload types come from scd_pkg at the instance
interface scd_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/scd_parser.sv
// command parser: parse state, argument accumulator, settings and enable flag
// depends on scd_pkg; one item is consumed at each cycle that fire is high
module scd_parser import scd_pkg::*; #(
	parameter int ARG_DIGITS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  in_item_t  item,
	output logic      res_valid,
	output out_item_t res
);

	localparam int ACC_W = $clog2(10 ** ARG_DIGITS);
	localparam int DC_W  = $clog2(ARG_DIGITS + 1);

	st_t                     st_q, st_d;
	logic [DC_W-1:0]         dcount_q, dcount_d;
	logic [ACC_W-1:0]        acc_q, acc_d, acc_new;
	logic [TGT_W-1:0]        tgt_q, tgt_d;
	logic [ACC_W-1:0]        set_q [NUM_SETTINGS];
	logic [7:0]              colour_q;
	logic                    en_q, en_d;

	logic [7:0]              b;
	logic                    is_digit, last_digit;
	logic                    own, forced, en_set, en_clr;
	logic                    set_we, colour_we;
	logic [SET_IDX_W-1:0]    rd_idx;
	logic                    rd_en;
	kind_t                   kind;
	logic [SET_IDX_W-1:0]    idx;
	logic [31:0]             val;

	assign b          = item.rx_byte;
	assign is_digit   = (b >= "0") && (b <= "9");
	assign last_digit = dcount_q == DC_W'(ARG_DIGITS - 1);
	assign acc_new    = ACC_W'({acc_q, 3'b000}) + ACC_W'({acc_q, 1'b0}) + ACC_W'(b[3:0]);

	// result of the current byte and whether its command forces the flag on
	always_comb begin
		own    = 1'b0;
		forced = 1'b0;
		en_set = 1'b0;
		en_clr = 1'b0;
		kind   = KIND_REPLY;
		idx    = '0;
		val    = '0;
		rd_en  = 1'b0;
		rd_idx = '0;
		unique case (st_q)
			ST_IDLE: begin
				if (b == "?") begin
					own = 1'b1;
				end else if (b == "r") begin
					own    = 1'b1;
					forced = 1'b1;
					kind   = KIND_RESET_SP;
				end
			end
			ST_CC, ST_S: forced = 1'b1;
			ST_CR: forced = !(b == "p" || b == "i" || b == "d");
			ST_CT: forced = !(b == "p" || b == "i" || b == "d");
			ST_D: forced = !(b == "a" || b == "r");
			ST_T: forced = !(b == "a" || b == "h");
			ST_E: begin
				if (b == "c") begin
					own    = 1'b1;
					forced = 1'b1;
					val    = 32'(colour_q);
				end else if (b == "i") begin
					own = 1'b1;
					val = 32'(en_q);
				end
			end
			ST_EM: begin
				forced = 1'b1;
				if (b == "r") begin
					rd_en  = 1'b1;
					rd_idx = SET_PWM_ROT;
				end else if (b == "t") begin
					rd_en  = 1'b1;
					rd_idx = SET_PWM_TR;
				end
			end
			ST_ER: begin
				forced = 1'b1;
				if (b == "p") begin
					rd_en  = 1'b1;
					rd_idx = SET_ROT_KP;
				end else if (b == "i") begin
					rd_en  = 1'b1;
					rd_idx = SET_ROT_KI;
				end else if (b == "d") begin
					rd_en  = 1'b1;
					rd_idx = SET_ROT_KD;
				end
			end
			ST_ET: begin
				forced = 1'b1;
				if (b == "p") begin
					rd_en  = 1'b1;
					rd_idx = SET_TR_KP;
				end else if (b == "i") begin
					rd_en  = 1'b1;
					rd_idx = SET_TR_KI;
				end else if (b == "d") begin
					rd_en  = 1'b1;
					rd_idx = SET_TR_KD;
				end
			end
			ST_I: begin
				if (b == "a") begin
					own    = 1'b1;
					kind   = KIND_ENABLE;
					en_set = 1'b1;
				end else if (b == "d") begin
					own    = 1'b1;
					kind   = KIND_ENABLE;
					en_clr = 1'b1;
				end
			end
			ST_X: begin
				forced = 1'b1;
				own    = b == "e";
				val    = item.position_x;
			end
			ST_Y: begin
				forced = 1'b1;
				own    = b == "e";
				val    = item.position_y;
			end
			ST_NUM: begin
				if (!is_digit) begin
					forced = 1'b1;
				end else if (last_digit) begin
					forced = 1'b1;
					if (!tgt_q[3]) begin
						own  = 1'b1;
						kind = KIND_SET_WRITE;
						idx  = tgt_q[SET_IDX_W-1:0];
						val  = 32'(acc_new);
					end else if (tgt_q == TGT_TR_POS) begin
						own  = 1'b1;
						kind = KIND_TRANSLATE;
						val  = 32'(acc_new);
					end else if (tgt_q == TGT_TR_NEG) begin
						own  = 1'b1;
						kind = KIND_TRANSLATE;
						val  = 32'(0) - 32'(acc_new);
					end else if (tgt_q == TGT_RO_POS) begin
						own  = 1'b1;
						kind = KIND_ROTATE;
						val  = 32'(acc_new);
					end else if (tgt_q == TGT_RO_NEG) begin
						own  = 1'b1;
						kind = KIND_ROTATE;
						val  = 32'(0) - 32'(acc_new);
					end
				end
			end
			default: ;
		endcase
		if (rd_en) begin
			own = 1'b1;
			val = 32'(set_q[rd_idx]);
		end
		// flag turned on by a command without a result of its own: given as an enable result
		if (!own && forced) begin
			kind = KIND_ENABLE;
			idx  = '0;
			val  = '0;
		end
	end

	always_comb begin
		en_d = en_q;
		if (forced || en_set) begin
			en_d = 1'b1;
		end else if (en_clr) begin
			en_d = 1'b0;
		end
	end

	assign res_valid         = own || (forced && !en_q);
	assign res.result_kind   = kind;
	assign res.setting_index = idx;
	assign res.value         = val;
	assign res.loop_enable   = en_d;

	// next parse state
	always_comb begin
		st_d      = ST_IDLE;
		tgt_d     = tgt_q;
		dcount_d  = dcount_q;
		acc_d     = acc_q;
		set_we    = 1'b0;
		colour_we = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (b == "c") st_d = ST_C;
				else if (b == "d") st_d = ST_D;
				else if (b == "e") st_d = ST_E;
				else if (b == "i") st_d = ST_I;
				else if (b == "s") st_d = ST_S;
				else if (b == "t") st_d = ST_T;
				else if (b == "x") st_d = ST_X;
				else if (b == "y") st_d = ST_Y;
			end
			ST_C: begin
				if (b == "c") st_d = ST_CC;
				else if (b == "m") st_d = ST_CM;
				else if (b == "r") st_d = ST_CR;
				else if (b == "t") st_d = ST_CT;
			end
			ST_CC: colour_we = (b == "r") || (b == "v");
			ST_CM: begin
				st_d = ST_NUM;
				if (b == "r") tgt_d = TGT_W'(SET_PWM_ROT);
				else if (b == "t") tgt_d = TGT_W'(SET_PWM_TR);
				else tgt_d = TGT_DISCARD;
			end
			ST_CR: begin
				st_d = ST_NUM;
				if (b == "p") tgt_d = TGT_W'(SET_ROT_KP);
				else if (b == "i") tgt_d = TGT_W'(SET_ROT_KI);
				else if (b == "d") tgt_d = TGT_W'(SET_ROT_KD);
				else st_d = ST_IDLE;
			end
			ST_CT: begin
				st_d = ST_NUM;
				if (b == "p") tgt_d = TGT_W'(SET_TR_KP);
				else if (b == "i") tgt_d = TGT_W'(SET_TR_KI);
				else if (b == "d") tgt_d = TGT_W'(SET_TR_KD);
				else st_d = ST_IDLE;
			end
			ST_D: begin
				st_d = ST_NUM;
				if (b == "a") tgt_d = TGT_TR_POS;
				else if (b == "r") tgt_d = TGT_TR_NEG;
				else st_d = ST_IDLE;
			end
			ST_T: begin
				st_d = ST_NUM;
				if (b == "a") tgt_d = TGT_RO_POS;
				else if (b == "h") tgt_d = TGT_RO_NEG;
				else st_d = ST_IDLE;
			end
			ST_E: begin
				if (b == "m") st_d = ST_EM;
				else if (b == "r") st_d = ST_ER;
				else if (b == "t") st_d = ST_ET;
			end
			ST_NUM: begin
				if (is_digit && !last_digit) begin
					st_d     = ST_NUM;
					acc_d    = acc_new;
					dcount_d = dcount_q + DC_W'(1);
				end
				set_we = is_digit && last_digit && !tgt_q[3];
			end
			default: ;
		endcase
		// entering an argument starts a fresh count
		if (st_d == ST_NUM && st_q != ST_NUM) begin
			dcount_d = '0;
			acc_d    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			dcount_q <= '0;
			acc_q    <= '0;
			tgt_q    <= '0;
			colour_q <= '0;
			en_q     <= 1'b0;
			for (int i = 0; i < NUM_SETTINGS; i++) begin
				set_q[i] <= '0;
			end
		end else if (fire) begin
			st_q     <= st_d;
			dcount_q <= dcount_d;
			acc_q    <= acc_d;
			tgt_q    <= tgt_d;
			en_q     <= en_d;
			if (colour_we) begin
				colour_q <= b;
			end
			if (set_we) begin
				set_q[tgt_q[SET_IDX_W-1:0]] <= acc_new;
			end
		end
	end

endmodule

### hw/rtl/serial_command_decoder.sv
// Serial command decoder. Each received byte enters an input register, is decoded
// against the parse state and its result, if any, lands in an output register, so
// a result is offered from the output register once its byte has left the input
// register. A new byte is taken every cycle; the only stall is a result held in the
// output register while the sink is not ready, which holds the byte in the input
// register behind it. The block keeps eight loop settings, a colour byte and the loop
// enable flag, all cleared by reset.
//
// top level: input and output registers around scd_parser
// depends on scd_pkg, scd_stream_if and serial_command_decoder_assert.svh
`include "serial_command_decoder_assert.svh"

module serial_command_decoder import scd_pkg::*; #(
	parameter int ARG_DIGITS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	scd_stream_if.sink    rx,
	scd_stream_if.source  res
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      fire;
	logic      p_valid;
	out_item_t p_res;
	logic      out_valid_q;
	out_item_t out_q;

	assign fire     = valid_s1 && (!out_valid_q || res.ready);
	assign rx.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (rx.valid && rx.ready) || (valid_s1 && !fire);
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			item_s1 <= rx.payload;
		end
	end

	scd_parser #(
		.ARG_DIGITS (ARG_DIGITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.res_valid (p_valid),
		.res       (p_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= p_valid;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && p_valid) begin
			out_q <= p_res;
		end
	end

	assign res.valid   = out_valid_q;
	assign res.payload = out_q;

	`SCD_NEVER(a_no_accept_on_stall, clk, arst_n, valid_s1 && !fire && rx.ready, "byte taken while input register is stalled")
	`SCD_ASSERT(a_index_only_on_write, clk, arst_n, !out_valid_q || out_q.result_kind == KIND_SET_WRITE || out_q.setting_index == NO_INDEX, "setting index on a result that is not a setting write")
	`SCD_ASSERT(a_flag_forced, clk, arst_n, !out_valid_q || out_q.result_kind == KIND_REPLY || out_q.result_kind == KIND_ENABLE || out_q.loop_enable, "move, reset or write without the loop enabled")
	`SCD_ASSERT(a_kind_range, clk, arst_n, !(fire && p_valid) || p_res.result_kind <= KIND_ENABLE, "result kind out of range")

endmodule
